@@ src/pdac_pkg.sv @@
// ============================================================================
// pdac_pkg
// Shared types and constants for the press duration alarm controller.
// ============================================================================
`default_nettype none

package pdac_pkg;

    // Default width of the internal time arithmetic
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HELP_DELAY = 8'd3;

    localparam logic [CFG_DATA_W-1:0] MIN_PRESS_RST  = 16'd20;
    localparam logic [CFG_DATA_W-1:0] SHORT_MAX_RST  = 16'd300;
    localparam logic [CFG_DATA_W-1:0] HOLD_LIMIT_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] HELP_DELAY_RST = 16'd3000;

    // Button tracker phase
    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_TIMEOUT  = 2'd2
    } phase_t;

    // Press classification
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ALARM   = 2'd1,
        EV_PICTURE = 2'd2,
        EV_CANCEL  = 2'd3
    } event_t;

    // Configuration register set
    typedef struct packed {
        logic [CFG_DATA_W-1:0] min_press_ms;
        logic [CFG_DATA_W-1:0] short_max_ms;
        logic [CFG_DATA_W-1:0] hold_limit_ms;
        logic [CFG_DATA_W-1:0] help_delay_ms;
    } cfg_regs_t;

    // Control flags kept between samples
    typedef struct packed {
        phase_t phase;
        logic   help_armed;
        logic   help_sent;
        logic   beeper_on;
        logic   camera_on;
        logic   led_r;
        logic   led_g;
        logic   led_b;
    } ctl_flags_t;

    localparam ctl_flags_t CTL_FLAGS_RST = '{
        phase:      PH_RELEASED,
        help_armed: 1'b0,
        help_sent:  1'b0,
        beeper_on:  1'b0,
        camera_on:  1'b0,
        led_r:      1'b1,
        led_g:      1'b0,
        led_b:      1'b1
    };

    // Input sample
    typedef struct packed {
        logic        button_level;
        logic [31:0] now_ms;
        logic        link_up;
    } sample_t;

    // Result item
    typedef struct packed {
        logic [1:0] press_event;
        logic       send_help;
        logic       beeper_running;
        logic       camera_running;
        logic       led_red_pin;
        logic       led_green_pin;
        logic       led_blue_pin;
    } result_t;

endpackage

`default_nettype wire

@@ src/pdac_step.sv @@
// ============================================================================
// pdac_step
// Next-state and result logic for one poll sample: button tracker, help
// timer and press classification.
// ============================================================================
`default_nettype none

module pdac_step
    import pdac_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire cfg_regs_t             cfg,
    input  wire ctl_flags_t            flags_cur,
    input  wire logic [TIME_WIDTH-1:0] start_cur,
    input  wire logic [TIME_WIDTH-1:0] act_cur,
    input  wire sample_t               sample,
    output ctl_flags_t                 flags_next,
    output logic [TIME_WIDTH-1:0]      start_next,
    output logic [TIME_WIDTH-1:0]      act_next,
    output result_t                    result
);

    logic [63:0]           now_wide;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] hold_time;
    logic [TIME_WIDTH-1:0] since_act;
    logic [TIME_WIDTH-1:0] min_t;
    logic [TIME_WIDTH-1:0] short_t;
    logic [TIME_WIDTH-1:0] hold_t;
    logic [TIME_WIDTH-1:0] delay_t;
    logic                  have_press;
    logic                  help;
    event_t                ev;

    // Timestamp truncated or zero-extended to the internal time width
    assign now_wide  = {32'd0, sample.now_ms};
    assign now_t     = now_wide[TIME_WIDTH-1:0];
    assign hold_time = now_t - start_cur;
    assign since_act = now_t - act_cur;
    assign min_t     = TIME_WIDTH'(cfg.min_press_ms);
    assign short_t   = TIME_WIDTH'(cfg.short_max_ms);
    assign hold_t    = TIME_WIDTH'(cfg.hold_limit_ms);
    assign delay_t   = TIME_WIDTH'(cfg.help_delay_ms);

    always_comb begin
        flags_next = flags_cur;
        start_next = start_cur;
        act_next   = act_cur;
        have_press = 1'b0;
        help       = 1'b0;
        ev         = EV_NONE;

        // Button tracker; the unused phase code behaves as pressed
        case (flags_cur.phase)
            PH_RELEASED: begin
                if (sample.button_level) begin
                    flags_next.phase = PH_PRESSED;
                    start_next       = now_t;
                end
            end
            default: begin
                if (!sample.button_level) begin
                    have_press       = (flags_cur.phase != PH_TIMEOUT);
                    flags_next.phase = PH_RELEASED;
                    start_next       = now_t;
                end else if (hold_time > hold_t) begin
                    have_press       = 1'b1;
                    flags_next.phase = PH_TIMEOUT;
                end
            end
        endcase

        // Help timer, against the activation time held before this sample
        if (flags_cur.help_armed && (since_act > delay_t) && sample.link_up) begin
            help                  = 1'b1;
            flags_next.help_armed = 1'b0;
            flags_next.help_sent  = 1'b1;
        end

        // Classification in priority order; bounce gives no event
        if (have_press) begin
            priority if (hold_time > min_t && hold_time <= short_t) begin
                ev = EV_ALARM;
            end else if (hold_time > short_t && hold_time <= hold_t) begin
                ev = EV_PICTURE;
            end else if (hold_time > hold_t) begin
                ev = EV_CANCEL;
            end else begin
                ev = EV_NONE;
            end
        end

        // Effects of the event
        unique case (ev)
            EV_ALARM, EV_PICTURE: begin
                flags_next.beeper_on = 1'b1;
                if (ev == EV_PICTURE) begin
                    flags_next.camera_on = 1'b1;
                end
                if (!flags_next.help_sent) begin
                    act_next              = now_t;
                    flags_next.help_armed = 1'b1;
                end
                flags_next.led_r = (ev == EV_ALARM);
                flags_next.led_g = 1'b1;
                flags_next.led_b = (ev == EV_PICTURE);
            end
            EV_CANCEL: begin
                flags_next.beeper_on  = 1'b0;
                flags_next.camera_on  = 1'b0;
                flags_next.help_armed = 1'b0;
                flags_next.help_sent  = 1'b0;
                flags_next.led_r      = 1'b1;
                flags_next.led_g      = 1'b0;
                flags_next.led_b      = 1'b1;
            end
            EV_NONE: begin
            end
        endcase
    end

    // Result fields follow the updated flags
    assign result.press_event    = ev;
    assign result.send_help      = help;
    assign result.beeper_running = flags_next.beeper_on;
    assign result.camera_running = flags_next.camera_on;
    assign result.led_red_pin    = flags_next.led_r;
    assign result.led_green_pin  = flags_next.led_g;
    assign result.led_blue_pin   = flags_next.led_b;

endmodule

`default_nettype wire

@@ src/press_duration_alarm_controller_unit.sv @@
// ============================================================================
// press_duration_alarm_controller_unit
// Panic button press classifier with beeper, camera, LED and help timer.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one poll sample (button level, ms timestamp,
//   link flag). Each sample gives exactly one result on m_valid/m_ready/m_data:
//   press event, help pulse, beeper/camera flags and active-low LED pins.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four 16-bit settings
//   (index 0..3); other indexes are dropped. cfg_ready is always high.
//   Latency: the result is valid the cycle after the sample transfer.
//   Throughput: one sample per cycle while the receiver takes each result;
//   the tracker state and the output register both update in the accept cycle.
//   A stalled receiver holds the result register; s_ready stays high as long
//   as the result register is empty or being drained in the same cycle.
//   Reset (aresetn low, synchronous) restores default settings, puts the
//   tracker in released phase, clears timers and flags, sets pins R1 G0 B1
//   and empties the result register.
// ============================================================================
`default_nettype none

module press_duration_alarm_controller_unit
    import pdac_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sample_t               s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output result_t                    m_data,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t             cfg_reg;
    ctl_flags_t            flags_reg;
    ctl_flags_t            flags_next;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] start_next;
    logic [TIME_WIDTH-1:0] act_reg;
    logic [TIME_WIDTH-1:0] act_next;
    logic                  m_valid_reg;
    result_t               m_data_reg;
    result_t               result;
    logic                  s_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_press_ms  <= MIN_PRESS_RST;
            cfg_reg.short_max_ms  <= SHORT_MAX_RST;
            cfg_reg.hold_limit_ms <= HOLD_LIMIT_RST;
            cfg_reg.help_delay_ms <= HELP_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_PRESS:  cfg_reg.min_press_ms  <= cfg_data;
                REG_SHORT_MAX:  cfg_reg.short_max_ms  <= cfg_data;
                REG_HOLD_LIMIT: cfg_reg.hold_limit_ms <= cfg_data;
                REG_HELP_DELAY: cfg_reg.help_delay_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Per-sample logic
    pdac_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .cfg        (cfg_reg),
        .flags_cur  (flags_reg),
        .start_cur  (start_reg),
        .act_cur    (act_reg),
        .sample     (s_data),
        .flags_next (flags_next),
        .start_next (start_next),
        .act_next   (act_next),
        .result     (result)
    );

    // Tracker state, updated on each sample transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= CTL_FLAGS_RST;
            start_reg <= '0;
            act_reg   <= '0;
        end else if (s_xfer) begin
            flags_reg <= flags_next;
            start_reg <= start_next;
            act_reg   <= act_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An armed timer never coexists with a sent help request
    a_armed_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(flags_reg.help_armed && flags_reg.help_sent))
        else $error("help timer armed after help was sent");

    // Camera only runs together with the beeper
    a_cam_beep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.camera_running || m_data.beeper_running))
        else $error("camera running without beeper");

    // A cancel result shows the idle LED pattern
    a_cancel_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.press_event == EV_CANCEL) |->
            (m_data.led_red_pin && !m_data.led_green_pin && m_data.led_blue_pin))
        else $error("cancel with wrong LED pins");

    // Every sample transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("result missing after sample transfer");

endmodule

`default_nettype wire

@@ verif/tb_press_duration_alarm_controller_unit.sv @@
// ============================================================================
// tb_press_duration_alarm_controller_unit
// Self-checking testbench for the panic button press classifier. A directed
// sequence covers bounce, alarm, picture, cancel, hold timeout, help timer,
// time wrap and backward time steps. Random press sequences then run under
// several register settings while both channels idle at random. A scoreboard
// predicts every result from the accepted samples and compares field by field.
// ============================================================================

module tb_press_duration_alarm_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pdac_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES    = 3;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the controller state and queues expected results
    // ------------------------------------------------------------------------
    class press_scoreboard;
        cfg_regs_t   cfg;
        phase_t      phase;
        logic [31:0] phase_start;
        logic        help_armed;
        logic [31:0] activation_ms;
        logic        help_sent;
        logic        beeper_on;
        logic        camera_on;
        logic [2:0]  led_pins;      // {red, green, blue}
        result_t     result_q[$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            cfg.min_press_ms  = MIN_PRESS_RST;
            cfg.short_max_ms  = SHORT_MAX_RST;
            cfg.hold_limit_ms = HOLD_LIMIT_RST;
            cfg.help_delay_ms = HELP_DELAY_RST;
            phase         = PH_RELEASED;
            phase_start   = '0;
            help_armed    = 1'b0;
            activation_ms = '0;
            help_sent     = 1'b0;
            beeper_on     = 1'b0;
            camera_on     = 1'b0;
            led_pins      = 3'b101;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MIN_PRESS:  cfg.min_press_ms  = val;
                REG_SHORT_MAX:  cfg.short_max_ms  = val;
                REG_HOLD_LIMIT: cfg.hold_limit_ms = val;
                REG_HELP_DELAY: cfg.help_delay_ms = val;
                default: ;      // unknown index: dropped
            endcase
        endfunction

        // Accepted sample: advance the state and queue the expected result
        function void note_sample(sample_t s);
            logic [31:0] held_ms;
            logic [31:0] since_act;
            logic [31:0] press_len;
            logic        have_press;
            logic        help;
            event_t      ev;
            result_t     want;

            held_ms    = s.now_ms - phase_start;
            since_act  = s.now_ms - activation_ms;
            press_len  = '0;
            have_press = 1'b0;
            help       = 1'b0;
            ev         = EV_NONE;

            // button tracker
            if (phase == PH_RELEASED) begin
                if (s.button_level) begin
                    phase       = PH_PRESSED;
                    phase_start = s.now_ms;
                end
            end else if (!s.button_level) begin
                if (phase != PH_TIMEOUT) begin
                    have_press = 1'b1;
                    press_len  = held_ms;
                end
                phase       = PH_RELEASED;
                phase_start = s.now_ms;
            end else if (held_ms > cfg.hold_limit_ms) begin
                have_press = 1'b1;
                press_len  = held_ms;
                phase      = PH_TIMEOUT;
            end

            // help timer, against the activation time before this sample
            if (help_armed && since_act > cfg.help_delay_ms && s.link_up) begin
                help       = 1'b1;
                help_armed = 1'b0;
                help_sent  = 1'b1;
            end

            // classification
            if (have_press) begin
                if (press_len > cfg.min_press_ms && press_len <= cfg.short_max_ms)
                    ev = EV_ALARM;
                else if (press_len > cfg.short_max_ms && press_len <= cfg.hold_limit_ms)
                    ev = EV_PICTURE;
                else if (press_len > cfg.hold_limit_ms)
                    ev = EV_CANCEL;
            end

            if (ev == EV_ALARM || ev == EV_PICTURE) begin
                beeper_on = 1'b1;
                if (ev == EV_PICTURE) camera_on = 1'b1;
                if (!help_sent) begin
                    activation_ms = s.now_ms;
                    help_armed    = 1'b1;
                end
                led_pins = (ev == EV_ALARM) ? 3'b110 : 3'b011;
            end else if (ev == EV_CANCEL) begin
                beeper_on  = 1'b0;
                camera_on  = 1'b0;
                help_armed = 1'b0;
                help_sent  = 1'b0;
                led_pins   = 3'b101;
            end

            want.press_event    = ev;
            want.send_help      = help;
            want.beeper_running = beeper_on;
            want.camera_running = camera_on;
            want.led_red_pin    = led_pins[2];
            want.led_green_pin  = led_pins[1];
            want.led_blue_pin   = led_pins[0];
            result_q.push_back(want);
        endfunction

        task report_mismatch(string what);
            errors++;
            // keep the log bounded on a badly broken design
            if (errors <= 100)
                $display("%0t: result %0d: %s", $realtime, results_seen, what);
        endtask

        task check_field(string name, logic [1:0] got, logic [1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        // Accepted result: compare with the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%0h", got));
            end else begin
                want = result_q.pop_front();
                check_field("press_event", got.press_event, want.press_event);
                check_field("send_help", got.send_help, want.send_help);
                check_field("beeper_running", got.beeper_running, want.beeper_running);
                check_field("camera_running", got.camera_running, want.camera_running);
                check_field("led_red_pin", got.led_red_pin, want.led_red_pin);
                check_field("led_green_pin", got.led_green_pin, want.led_green_pin);
                check_field("led_blue_pin", got.led_blue_pin, want.led_blue_pin);
            end
            results_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sample_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    result_t               m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    press_scoreboard sb = new();

    logic        no_idle      = 1'b0;   // last part of the run: no idling
    logic        hold_off_req = 1'b0;   // receiver long hold-off request
    logic [31:0] t_ms         = '0;     // running millisecond time base
    int unsigned samples_sent = 0;

    press_duration_alarm_controller_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Monitor: every transfer goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_sample(s_data);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles without a transfer
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("[press_duration_alarm_controller_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each returns at a falling edge
    // ------------------------------------------------------------------------

    // Offer one sample; valid is left high so back-to-back transfers need no toggle
    task automatic send_sample(input logic btn, input logic [31:0] now, input logic lnk);
        sample_t smp;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        smp.button_level = btn;
        smp.now_ms       = now;
        smp.link_up      = lnk;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Sender pause until every expected result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Idle block, then all four registers plus one write to an unused index
    task automatic apply_settings(input logic [15:0] min_v, input logic [15:0] short_v,
                                  input logic [15:0] hold_v, input logic [15:0] delay_v);
        wait_drained();
        write_reg(REG_MIN_PRESS, min_v);
        write_reg(REG_SHORT_MAX, short_v);
        write_reg(REG_HOLD_LIMIT, hold_v);
        write_reg(REG_HELP_DELAY, delay_v);
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic rand_link();
        return ($urandom_range(0, 3) != 0);
    endfunction

    // Press length aimed mostly at the classification boundaries
    function automatic logic [31:0] pick_press_len();
        logic [31:0] base;
        case ($urandom_range(0, 6))
            0: base = sb.cfg.min_press_ms;
            1: base = sb.cfg.short_max_ms;
            2: base = sb.cfg.hold_limit_ms;
            3: base = $urandom_range(0, 2 * sb.cfg.hold_limit_ms + 2);
            4: base = $urandom_range(0, 3);
            5: base = $urandom_range(0, 70000);
            default: base = $urandom();
        endcase
        return base + $urandom_range(0, 2) - 1;
    endfunction

    // Well-formed press: lead-in, press, hold samples, release, help probes
    task automatic press_sequence();
        logic [31:0] len;
        logic [31:0] start_ms;
        logic [31:0] step;
        logic [31:0] rel_ms;
        int unsigned n_hold;
        logic        lnk;
        logic        overrun;

        lnk     = rand_link();
        overrun = ($urandom_range(0, 4) == 0);
        len     = overrun ? 32'(sb.cfg.hold_limit_ms) + 5 + $urandom_range(0, 100)
                          : pick_press_len();

        t_ms = t_ms + $urandom_range(1, 40);
        send_sample(1'b0, t_ms, lnk);
        t_ms     = t_ms + $urandom_range(1, 40);
        start_ms = t_ms;
        send_sample(1'b1, start_ms, rand_link());

        if (overrun) begin
            // held past the limit: cancel on every sample
            for (int j = 0; j < 3; j++)
                send_sample(1'b1, start_ms + sb.cfg.hold_limit_ms + 1 + j, rand_link());
        end else begin
            n_hold = $urandom_range(0, 3);
            step   = len / (n_hold + 1);
            for (int i = 1; i <= n_hold; i++)
                send_sample(1'b1, start_ms + step * i, rand_link());
        end

        rel_ms = start_ms + len;
        t_ms   = rel_ms;
        send_sample(1'b0, rel_ms, rand_link());

        // probe around the help delay after the release
        if ($urandom_range(0, 1)) begin
            for (int k = 0; k < $urandom_range(1, 3); k++) begin
                t_ms = rel_ms + sb.cfg.help_delay_ms - 1 + k;
                send_sample(1'b0, t_ms, rand_link());
            end
        end
    endtask

    // Noise: arbitrary samples, including jumps and broken presses
    task automatic noise_burst();
        logic [31:0] now;
        for (int i = 0; i < $urandom_range(1, 4); i++) begin
            now = ($urandom_range(0, 1)) ? $urandom() : t_ms + $urandom_range(0, 5000);
            if ($urandom_range(0, 1)) t_ms = now;
            send_sample(1'($urandom_range(0, 1)), now, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8)
                press_sequence();
            else
                noise_burst();
        end
    endtask

    // Directed part, default settings 20/300/1000/3000
    task automatic run_directed();
        send_sample(1'b0, 32'd0, 1'b0);             // reset pin levels
        send_sample(1'b1, 32'd100, 1'b0);
        send_sample(1'b0, 32'd120, 1'b0);           // bounce at the minimum
        send_sample(1'b1, 32'd200, 1'b1);
        send_sample(1'b0, 32'd221, 1'b1);           // shortest alarm, arms help
        send_sample(1'b0, 32'd3221, 1'b1);          // delay reached, not passed
        send_sample(1'b0, 32'd3222, 1'b0);          // link down holds help
        send_sample(1'b0, 32'd3222, 1'b1);          // help pulse
        send_sample(1'b1, 32'd4000, 1'b1);
        send_sample(1'b0, 32'd4300, 1'b1);          // longest alarm, help already sent
        send_sample(1'b1, 32'd4400, 1'b0);
        send_sample(1'b0, 32'd4701, 1'b0);          // shortest picture alarm
        send_sample(1'b1, 32'd5000, 1'b0);
        send_sample(1'b1, 32'd6000, 1'b0);          // at the limit, still held
        send_sample(1'b1, 32'd6001, 1'b0);          // past the limit: cancel
        send_sample(1'b1, 32'd6002, 1'b1);          // cancel repeats while held
        send_sample(1'b0, 32'd6003, 1'b1);          // release after timeout
        send_sample(1'b1, 32'hFFFF_FF00, 1'b1);
        send_sample(1'b0, 32'h0000_0010, 1'b1);     // press across the time wrap
        send_sample(1'b1, 32'hFFFF_FFFF, 1'b1);     // help timer sees a huge gap
        send_sample(1'b0, 32'hFFFF_FFFE, 1'b0);     // backward step on release
        send_sample(1'b1, 32'd500, 1'b0);
        send_sample(1'b1, 32'd400, 1'b0);           // backward step while held
        send_sample(1'b0, 32'hFFFF_FFFF, 1'b1);
        send_sample(1'b0, 32'd0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        wait_drained();

        // defaults; receiver holds off while samples keep coming
        t_ms         = $urandom();
        hold_off_req = 1'b1;
        run_random(60);

        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(50);

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        t_ms = 32'hFFFF_F000;
        run_random(40);
        wait_drained();
        run_random(30);

        // overlapping ranges
        apply_settings(16'd500, 16'd100, 16'd300, 16'd50);
        run_random(60);

        apply_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 2000)), 16'($urandom_range(0, 5000)));
        run_random(60);

        // final stretch without idling
        apply_settings(MIN_PRESS_RST, SHORT_MAX_RST, HOLD_LIMIT_RST, HELP_DELAY_RST);
        no_idle = 1'b1;
        run_random(80);

        wait_drained();
        if (sb.errors == 0)
            $display("[press_duration_alarm_controller_unit] OK");
        else
            $display("[press_duration_alarm_controller_unit] ERROR");
        $finish;
    end

endmodule
